// ===== sv/b64_pkg.sv =====
package b64_pkg;

  localparam int unsigned SlotN   = 4;
  localparam int unsigned NumW    = 3;
  localparam logic [7:0]  PadChar = 8'h3D;

  typedef enum logic {
    DirEncode = 1'b0,
    DirDecode = 1'b1
  } b64_dir_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       bad;
  } b64_res_t;

  typedef struct packed {
    b64_res_t [SlotN-1:0] res;
    logic [NumW-1:0]      num;
    logic                 done;
  } b64_batch_t;

  typedef struct packed {
    logic [23:0] hold;
    logic [1:0]  cnt;
    logic        disc;
  } b64_state_t;

  function automatic logic [7:0] b64_char(input logic [5:0] six);
    logic [7:0] x;
    x = {2'b00, six};
    if (six < 6'd26) begin
      return 8'h41 + x;
    end else if (six < 6'd52) begin
      return 8'h61 + x - 8'd26;
    end else if (six < 6'd62) begin
      return 8'h30 + x - 8'd52;
    end else if (six == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  // bit 6: character is in the alphabet, bits 5:0: its sextet
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
      return {1'b1, d[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61 + 8'd26;
      return {1'b1, d[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30 + 8'd52;
      return {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end else begin
      return {1'b0, d[5:0]};
    end
  endfunction

endpackage

// ===== sv/b64_step.sv =====
module b64_step (
  input  b64_pkg::b64_dir_e   dir_i,
  input  b64_pkg::b64_state_t state_i,
  input  logic [7:0]          byte_i,
  input  logic                end_i,
  output b64_pkg::b64_batch_t batch_o,
  output b64_pkg::b64_state_t state_o
);
  import b64_pkg::*;

  logic [23:0] h1;
  logic [1:0]  c1;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [6:0]  sx;
  logic        pad;
  logic        pseen;
  logic [5:0]  val;
  logic [23:0] s;

  function automatic b64_res_t data_res(input logic [7:0] d);
    b64_res_t r;
    r.data = d;
    r.has  = 1'b1;
    r.bad  = 1'b0;
    return r;
  endfunction

  assign h1    = {state_i.hold[15:0], byte_i};
  assign c1    = state_i.cnt + 2'd1;
  assign b0    = (c1 == 2'd2) ? h1[15:8] : h1[7:0];
  assign b1    = h1[7:0];
  assign sx    = b64_sextet(byte_i);
  assign pad   = (byte_i == PadChar);
  assign pseen = state_i.hold[23];
  assign val   = pad ? 6'd0 : sx[5:0];
  assign s     = {state_i.hold[17:0], val};

  always_comb begin
    batch_o = '0;
    state_o = state_i;
    if (dir_i == DirEncode) begin
      state_o.hold = h1;
      state_o.cnt  = c1;
      if (c1 == 2'd3) begin
        batch_o.res[0] = data_res(b64_char(h1[23:18]));
        batch_o.res[1] = data_res(b64_char(h1[17:12]));
        batch_o.res[2] = data_res(b64_char(h1[11:6]));
        batch_o.res[3] = data_res(b64_char(h1[5:0]));
        batch_o.num    = 3'd4;
        state_o.hold   = '0;
        state_o.cnt    = '0;
      end else if (end_i) begin
        batch_o.res[0] = data_res(b64_char(b0[7:2]));
        if (c1 == 2'd1) begin
          batch_o.res[1] = data_res(b64_char({b0[1:0], 4'b0000}));
          batch_o.res[2] = data_res(PadChar);
        end else begin
          batch_o.res[1] = data_res(b64_char({b0[1:0], b1[7:4]}));
          batch_o.res[2] = data_res(b64_char({b1[3:0], 2'b00}));
        end
        batch_o.res[3] = data_res(PadChar);
        batch_o.num    = 3'd4;
      end
    end else begin
      if (state_i.disc) begin
        if (end_i) begin
          state_o.disc = 1'b0;
        end
      end else if ((!sx[6] && !pad) || (pad && state_i.cnt < 2'd2) || (pseen && !pad)) begin
        batch_o.res[0].bad = 1'b1;
        batch_o.num        = 3'd1;
        state_o.hold       = '0;
        state_o.cnt        = '0;
        state_o.disc       = !end_i;
      end else if (state_i.cnt != 2'd3) begin
        state_o.hold = {pseen | pad, 5'b00000, state_i.hold[11:0], val};
        state_o.cnt  = state_i.cnt + 2'd1;
      end else begin
        batch_o.res[0] = data_res(s[23:16]);
        batch_o.num    = 3'd1;
        if (!pseen) begin
          batch_o.res[1] = data_res(s[15:8]);
          batch_o.num    = 3'd2;
          if (!pad) begin
            batch_o.res[2] = data_res(s[7:0]);
            batch_o.num    = 3'd3;
          end
        end
        state_o.hold = '0;
        state_o.cnt  = '0;
      end
    end
    if (end_i) begin
      state_o.hold = '0;
      state_o.cnt  = '0;
      if (batch_o.num == '0) begin
        batch_o.num = 3'd1;
      end
    end
    batch_o.done = end_i;
  end

endmodule

// ===== sv/b64_emit.sv =====
module b64_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  b64_pkg::b64_batch_t batch_i,
  output logic                free_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,  // out_byte
  output logic                m_axis_tlast_o,  // message_done
  output logic [2:0]          m_axis_tuser_o   // has_data, bad_char, run_last
);
  import b64_pkg::*;

  b64_res_t [SlotN-1:0] res_q;
  b64_res_t [SlotN-1:0] res_d;
  logic [NumW-1:0]      num_q;
  logic [NumW-1:0]      num_d;
  logic                 done_q;
  logic                 done_d;
  logic                 empty;
  logic                 pop;
  logic                 run_last;

  assign empty           = (num_q == '0);
  assign m_axis_tvalid_o = !empty;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign run_last        = (num_q == NumW'(1));
  assign free_o          = empty || (pop && run_last);
  assign m_axis_tdata_o  = res_q[0].data;
  assign m_axis_tlast_o  = done_q && run_last;
  assign m_axis_tuser_o  = {run_last, res_q[0].bad, res_q[0].has};

  always_comb begin
    res_d  = res_q;
    num_d  = num_q;
    done_d = done_q;
    if (load_i) begin
      res_d  = batch_i.res;
      num_d  = batch_i.num;
      done_d = batch_i.done;
    end else if (pop) begin
      for (int i = 0; i < SlotN - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      res_d[SlotN-1] = '0;
      num_d          = num_q - NumW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
    end else begin
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    done_q <= done_d;
  end

  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_q <= NumW'(SlotN))
    else $error("result count out of range");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> empty || (pop && run_last))
    else $error("batch loaded over pending results");

  a_pop_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && num_q > NumW'(1) |=> m_axis_tvalid_o)
    else $error("results lost after transfer");

  a_bad_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tuser_o[0] && m_axis_tdata_o == 8'h00)
    else $error("error result carries data");

endmodule

// ===== sv/base64_codec_top.sv =====
// Each input item is registered, then its results are loaded into the result buffer and
// offered from there one per output transfer; the next batch loads on the last transfer
// of the one before, or while the buffer is empty.
// Reset (asynchronous, active low) selects encode and empties group, input and results.
module base64_codec_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,      // direction
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // in_byte
  input  logic       s_axis_tlast_i,   // msg_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // out_byte
  output logic       m_axis_tlast_o,   // message_done
  output logic [2:0] m_axis_tuser_o    // has_data, bad_char, run_last
);
  import b64_pkg::*;

  b64_dir_e   dir_q;
  b64_state_t state_q;
  b64_state_t state_nxt;
  b64_batch_t batch;
  logic       in_valid_q;
  logic       in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       free;
  logic       move;
  logic       accept;

  assign move            = in_valid_q && free;
  assign s_axis_tready_o = !in_valid_q || free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (move) begin
      in_valid_d = 1'b0;
    end
  end

  b64_step u_step (
    .dir_i   (dir_q),
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .end_i   (in_end_q),
    .batch_o (batch),
    .state_o (state_nxt)
  );

  b64_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (move),
    .batch_i         (batch),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= DirEncode;
      state_q    <= '0;
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        dir_q   <= b64_dir_e'(cfg_wdata_i);
        state_q <= '0;
      end else if (move) begin
        state_q <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_end_q  <= s_axis_tlast_i;
    end
  end

  a_move_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && !accept |=> !in_valid_q)
    else $error("input register not released");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !free |=> in_valid_q && $stable(in_byte_q) && $stable(in_end_q))
    else $error("pending input item changed");

  a_encode_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q == DirEncode && !cfg_we_i |=> !state_q.disc)
    else $error("discard flag set while encoding");

endmodule
